// File: rtl/assert_macros.svh
// Assertion macros used by rtl/timed_event_playback.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/tep_pkg.sv
// Types and constants of the timed event playback block.
package tep_pkg;

   localparam int FRAME_W     = 32;
   localparam int COUNT_W     = 9;
   localparam int CSR_INDEX_W = 4;

   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_RESTART = 2'd1;
   localparam logic [1:0] REQ_TICK    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_STAGE_LENGTH   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECKPOINT_ONE = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECKPOINT_TWO = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EVENT_COUNT    = 4'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [7:0]         entry_index;
      logic [FRAME_W-1:0] entry_frame;
      logic               entry_kind;
      logic [7:0]         entry_variant;
      logic signed [15:0] entry_x;
      logic signed [15:0] entry_y;
      logic [1:0]         resume_checkpoint;
   } req_beat_type;

   typedef struct packed {
      logic               event_valid;
      logic               event_kind;
      logic [7:0]         event_variant;
      logic signed [15:0] event_x;
      logic signed [15:0] event_y;
      logic [1:0]         passed_checkpoints;
      logic               stage_done;
      logic [FRAME_W-1:0] frame_now;
      logic               last;
   } rsp_beat_type;

   typedef struct packed {
      logic               kind;
      logic [7:0]         variant;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } payload_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      payload_type        payload;
   } entry_type;

endpackage

// File: rtl/timed_event_playback.sv
// Timed event playback: event table, frame counter, checkpoint tally and playback sequencer.
//
//   channel   signals                                  flow
//   request   start, busy, req_beat                    taken when start and not busy
//   result    rsp_valid, rsp_beat                      one cycle per beat, no back-pressure
//   config    csr_valid, csr_ready, csr_index/data     taken when valid and ready
//
// A load or an unknown request does not raise busy; its beat follows on the next cycle.
// A restart or tick stays busy while it tests the checkpoints left, the stage length and each
// entry passed or emitted; its final beat follows on the next cycle. Every entry costs one table
// read and one pass through the shared 32-bit comparator. Results cannot be stalled; the block
// is busy until the final beat. Reset is synchronous and clears the state, counters, tally,
// cursor, flags and config registers; the table, read, held-event and beat data are not reset.
`include "assert_macros.svh"

module timed_event_playback
   import tep_pkg::*;
#(
   parameter int TABLE_DEPTH  = 256,
   parameter int MAX_PER_TICK = 16,
   parameter int CHECKPOINTS  = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  req_beat_type           req_beat,
   output logic                   busy,
   output logic                   rsp_valid,
   output rsp_beat_type           rsp_beat,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FRAME_W-1:0]     csr_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int XW = (CW > 8) ? CW : 8;
   localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int KW = $clog2(MAX_PER_TICK + 1);
   localparam int NC = (CHECKPOINTS < 2) ? CHECKPOINTS : 2;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CP   = 3'd1;
   localparam logic [2:0] ST_STG  = 3'd2;
   localparam logic [2:0] ST_RD   = 3'd3;
   localparam logic [2:0] ST_CMP  = 3'd4;

   entry_type mem [TABLE_DEPTH];

   logic [2:0]         state_ff, state_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [1:0]         tally_ff, tally_in;
   logic [CW-1:0]      cursor_ff, cursor_in;
   logic [KW-1:0]      count_ff, count_in;
   logic [1:0]         ci_ff, ci_in;
   logic               tick_ff, tick_in;
   logic               done_ff, done_in;
   logic               pend_valid_ff, pend_valid_in;
   payload_type        pend_ff, pend_in;
   entry_type          rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_beat_type       rsp_ff, rsp_in;

   logic [FRAME_W-1:0] stage_length_ff, cp_one_ff, cp_two_ff;
   logic [COUNT_W-1:0] event_count_ff;

   logic               accept;
   logic [XW-1:0]      idx_x;
   logic               wr_en;
   logic [CW-1:0]      used;
   logic [FRAME_W-1:0] op_a, op_b;
   logic               lt;
   logic [1:0]         cp_req;
   logic [FRAME_W-1:0] res_frame;
   logic               in_range;
   logic               count_ok;
   logic               emit, emit_ev, emit_last, emit_done;
   payload_type        emit_pl;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   assign idx_x = XW'(req_beat.entry_index);
   assign wr_en = accept && (req_beat.req_type == REQ_LOAD) && (idx_x < XW'(TABLE_DEPTH));

   always_comb begin
      if (NW'(event_count_ff) > NW'(TABLE_DEPTH)) begin
         used = CW'(TABLE_DEPTH);
      end else begin
         used = CW'(event_count_ff);
      end
   end

   assign in_range = (cursor_ff < used);
   assign count_ok = (count_ff < KW'(MAX_PER_TICK));

   always_comb begin
      if (req_beat.resume_checkpoint > 2'(NC)) begin
         cp_req = 2'(NC);
      end else begin
         cp_req = req_beat.resume_checkpoint;
      end
      case (cp_req)
         2'd0:    res_frame = '0;
         2'd1:    res_frame = cp_one_ff;
         default: res_frame = cp_two_ff;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_CP: begin
            op_a = frame_ff;
            op_b = (ci_ff == 2'd0) ? cp_one_ff : cp_two_ff;
         end
         ST_CMP: begin
            op_a = tick_ff ? frame_ff : rd_ff.frame;
            op_b = tick_ff ? rd_ff.frame : frame_ff;
         end
         default: begin
            op_a = frame_ff;
            op_b = stage_length_ff;
         end
      endcase
   end

   assign lt = (op_a < op_b);

   always_comb begin
      state_in      = state_ff;
      frame_in      = frame_ff;
      tally_in      = tally_ff;
      cursor_in     = cursor_ff;
      count_in      = count_ff;
      ci_in         = ci_ff;
      tick_in       = tick_ff;
      done_in       = done_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      emit          = 1'b0;
      emit_ev       = 1'b0;
      emit_last     = 1'b1;
      emit_done     = done_ff;
      emit_pl       = '0;

      case (state_ff)
         ST_IDLE: begin
            emit_done = !lt;
            if (accept) begin
               case (req_beat.req_type)
                  REQ_RESTART: begin
                     frame_in      = res_frame;
                     tally_in      = 2'd0;
                     ci_in         = 2'd0;
                     cursor_in     = '0;
                     count_in      = '0;
                     tick_in       = 1'b0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_CP;
                  end
                  REQ_TICK: begin
                     frame_in      = frame_ff + 32'd1;
                     ci_in         = tally_ff;
                     count_in      = '0;
                     tick_in       = 1'b1;
                     pend_valid_in = 1'b0;
                     state_in      = ST_CP;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_CP: begin
            if (ci_ff >= 2'(NC)) begin
               state_in = ST_STG;
            end else begin
               if (!lt) begin
                  tally_in = ci_ff + 2'd1;
               end
               ci_in = ci_ff + 2'd1;
            end
         end
         ST_STG: begin
            done_in  = !lt;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (tick_ff) begin
               if (in_range && count_ok && !lt) begin
                  emit          = pend_valid_ff;
                  emit_ev       = 1'b1;
                  emit_last     = 1'b0;
                  emit_pl       = pend_ff;
                  pend_in       = rd_ff.payload;
                  pend_valid_in = 1'b1;
                  cursor_in     = cursor_ff + 1'b1;
                  count_in      = count_ff + 1'b1;
                  state_in      = ST_RD;
               end else begin
                  emit          = 1'b1;
                  emit_ev       = pend_valid_ff;
                  emit_pl       = pend_valid_ff ? pend_ff : '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               if (in_range && lt) begin
                  cursor_in = cursor_ff + 1'b1;
                  state_in  = ST_RD;
               end else begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_in.event_valid        = emit_ev;
         rsp_in.event_kind         = emit_pl.kind;
         rsp_in.event_variant      = emit_pl.variant;
         rsp_in.event_x            = emit_pl.x;
         rsp_in.event_y            = emit_pl.y;
         rsp_in.passed_checkpoints = tally_ff;
         rsp_in.stage_done         = emit_done;
         rsp_in.frame_now          = frame_ff;
         rsp_in.last               = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_x[AW-1:0]] <= '{frame:   req_beat.entry_frame,
                                 payload: '{kind:    req_beat.entry_kind,
                                            variant: req_beat.entry_variant,
                                            x:       req_beat.entry_x,
                                            y:       req_beat.entry_y}};
      end
      rd_ff <= mem[cursor_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         frame_ff        <= '0;
         tally_ff        <= '0;
         cursor_ff       <= '0;
         count_ff        <= '0;
         ci_ff           <= '0;
         tick_ff         <= 1'b0;
         done_ff         <= 1'b0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         stage_length_ff <= '0;
         cp_one_ff       <= '0;
         cp_two_ff       <= '0;
         event_count_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         frame_ff      <= frame_in;
         tally_ff      <= tally_in;
         cursor_ff     <= cursor_in;
         count_ff      <= count_in;
         ci_ff         <= ci_in;
         tick_ff       <= tick_in;
         done_ff       <= done_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STAGE_LENGTH:   stage_length_ff <= csr_data;
               CSR_CHECKPOINT_ONE: cp_one_ff       <= csr_data;
               CSR_CHECKPOINT_TWO: cp_two_ff       <= csr_data;
               CSR_EVENT_COUNT:    event_count_ff  <= csr_data[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   `ASSERT_RST(a_count_bound, clock, reset, count_ff <= KW'(MAX_PER_TICK), "tick count past limit")
   `ASSERT_RST(a_tally_bound, clock, reset, tally_ff <= 2'(NC), "checkpoint tally past limit")
   `ASSERT_RST(a_more_follows, clock, reset, rsp_valid_ff && !rsp_ff.last |=> busy && !rsp_valid_ff, "beat without last not followed by table read")
   `ASSERT_RST(a_pend_tick, clock, reset, pend_valid_ff |-> tick_ff && busy, "held event outside tick")
   `ASSERT_RST(a_reset_idle, clock, reset, $past(reset) |-> !busy && !rsp_valid, "not idle after reset")
   `ASSERT_ALWAYS(a_csr_ready, clock, csr_ready, "config port not ready")

endmodule
